[src/lphm_pkg.sv]
// Package for the linear-probing hash map: request/response structs,
// status codes and hash constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lphm_pkg;

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Response status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Hash multiplier and miss value
    localparam logic [31:0] HASH_MULT  = 32'd3474692833;
    localparam logic [63:0] MISS_VALUE = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic        req_type;
        logic [63:0] key;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] result_value;
    } t_rsp;

endpackage
`default_nettype wire

[src/linear_probe_hash_map_top.sv]
// Top level of the linear-probing hash map: sequencer, slot memories and
// response register. Depends on lphm_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Open-addressing key/value map with linear probing. After reset the block
// runs a clearing pass over the slot status memory and stalls requests
// meanwhile. One request at a time is processed: the home slot status is
// read (S_HRD) and checked (S_HCHK), then each slot probed is read (S_PRD)
// and compared (S_PCHK); an insert of a new key then reads and checks
// slots in the free-slot search (S_FRD, S_FCHK) and writes in S_W1 and
// S_W2; S_RESP loads the response register once the previous one is taken.
// An insert is refused with status full once the map holds TABLE_DEPTH/2
// entries. TABLE_DEPTH must be a power of two.
module linear_probe_hash_map_top
    import lphm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    output logic o_req_stall,
    input  wire t_req i_req,
    output logic o_rsp_valid,
    input  wire  i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W;
    localparam logic [CNT_W-1:0] HALF = CNT_W'(TABLE_DEPTH / 2);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HRD  = 4'd2;
    localparam logic [3:0] S_HCHK = 4'd3;
    localparam logic [3:0] S_PRD  = 4'd4;
    localparam logic [3:0] S_PCHK = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FCHK = 4'd7;
    localparam logic [3:0] S_W1   = 4'd8;
    localparam logic [3:0] S_W2   = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    // Home slot: low bits of key times the multiplier
    function automatic logic [IDX_W-1:0] hash_slot(input logic [63:0] k);
        logic [31:0] p;
        p = {16'b0, k[15:0]} * {16'b0, HASH_MULT[15:0]};
        return p[IDX_W-1:0];
    endfunction

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_home, n_home;
    logic             r_type, n_type;
    logic [63:0]      r_key, n_key;
    logic [63:0]      r_val, n_val;
    logic [CNT_W-1:0] r_need, n_need;
    logic             r_home_full, n_home_full;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0] r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_res_status, n_res_status;
    logic [63:0]      r_res_val, n_res_val;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic [CNT_W:0]   r_st_mem [TABLE_DEPTH];
    logic [63:0]      r_key_mem [TABLE_DEPTH];
    logic [63:0]      r_val_mem [TABLE_DEPTH];
    logic [CNT_W:0]   r_st_rd;
    logic [63:0]      r_key_rd;
    logic [63:0]      r_val_rd;

    logic             w_st_we;
    logic [IDX_W-1:0] w_st_addr;
    logic [CNT_W:0]   w_st_wdata;
    logic             w_kv_we;
    logic             w_rd_full;
    logic [CNT_W-1:0] w_rd_cnt;
    logic [CNT_W-1:0] w_seen_inc;
    logic             w_accept;

    assign w_rd_full  = r_st_rd[0];
    assign w_rd_cnt   = r_st_rd[CNT_W:1];
    assign w_accept   = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Slot memories: one write, one registered read at the probe index
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            r_st_mem[w_st_addr] <= w_st_wdata;
        end
        if (w_kv_we) begin
            r_key_mem[r_idx] <= r_key;
            r_val_mem[r_idx] <= r_val;
        end
        r_st_rd  <= r_st_mem[r_idx];
        r_key_rd <= r_key_mem[r_idx];
        r_val_rd <= r_val_mem[r_idx];
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_home       = r_home;
        n_type       = r_type;
        n_key        = r_key;
        n_val        = r_val;
        n_need       = r_need;
        n_home_full  = r_home_full;
        n_seen       = r_seen;
        n_free_cnt   = r_free_cnt;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_st_we      = 1'b0;
        w_st_addr    = r_idx;
        w_st_wdata   = '0;
        w_kv_we      = 1'b0;
        w_seen_inc   = r_seen + 1'b1;

        // Drop the response once taken
        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                w_st_we = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_type  = i_req.req_type;
                    n_key   = i_req.key;
                    n_val   = i_req.value;
                    n_home  = hash_slot(i_req.key);
                    n_idx   = hash_slot(i_req.key);
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                n_state = S_HCHK;
            end
            S_HCHK: begin
                n_need      = w_rd_cnt;
                n_home_full = w_rd_full;
                n_seen      = '0;
                if (w_rd_cnt == '0) begin
                    n_state = S_RESP;
                    if (r_type == REQ_LOOKUP) begin
                        n_res_status = ST_NOT_FOUND;
                        n_res_val    = MISS_VALUE;
                    end else if (r_count >= HALF) begin
                        n_res_status = ST_FULL;
                        n_res_val    = '0;
                    end else begin
                        n_state = S_FRD;
                    end
                end else begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (w_rd_full && r_key_rd == r_key) begin
                    // Hit
                    n_state = S_RESP;
                    if (r_type == REQ_LOOKUP) begin
                        n_res_status = ST_FOUND;
                        n_res_val    = r_val_rd;
                    end else begin
                        n_res_status = ST_PRESENT;
                        n_res_val    = '0;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (w_rd_full && hash_slot(r_key_rd) == r_home) begin
                        n_seen = w_seen_inc;
                    end
                    if (w_rd_full && hash_slot(r_key_rd) == r_home
                        && w_seen_inc == r_need) begin
                        // Every key homed here seen: miss
                        n_state = S_RESP;
                        if (r_type == REQ_LOOKUP) begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_val    = MISS_VALUE;
                        end else if (r_count >= HALF) begin
                            n_res_status = ST_FULL;
                            n_res_val    = '0;
                        end else begin
                            n_state = S_FRD;
                        end
                    end else begin
                        n_state = S_PRD;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (w_rd_full) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FRD;
                end else begin
                    n_free_cnt = w_rd_cnt;
                    n_state    = S_W1;
                end
            end
            S_W1: begin
                // Store the pair and mark the slot full
                w_kv_we    = 1'b1;
                w_st_we    = 1'b1;
                w_st_wdata = {r_free_cnt, 1'b1};
                n_state    = S_W2;
            end
            S_W2: begin
                // Bump the home count
                w_st_we      = 1'b1;
                w_st_addr    = r_home;
                w_st_wdata   = {CNT_W'(r_need + 1'b1), r_home_full || (r_idx == r_home)};
                n_count      = r_count + 1'b1;
                n_res_status = ST_INSERTED;
                n_res_val    = '0;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_res_status;
                    n_out.result_value = r_res_val;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_home       <= n_home;
        r_type       <= n_type;
        r_key        <= n_key;
        r_val        <= n_val;
        r_need       <= n_need;
        r_home_full  <= n_home_full;
        r_seen       <= n_seen;
        r_free_cnt   <= n_free_cnt;
        r_res_status <= n_res_status;
        r_res_val    <= n_res_val;
        r_out        <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HALF)
        else $error("entry count above half capacity");

    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W2) |-> ($past(r_state) == S_W1))
        else $error("home count update without pair write");

    a_seen_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCHK) |-> (r_seen < r_need))
        else $error("probe continued after all homed keys seen");

    a_insert_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W1) |-> (r_count < HALF && r_type == REQ_INSERT))
        else $error("insert past half capacity");
`endif

endmodule
`default_nettype wire

[tb/lphm_checker.sv]
// Checker for the linear-probing hash map: watches request and response
// transactions, predicts each response and compares. Depends on lphm_pkg.
`timescale 1ns / 1ps
module lphm_checker
    import lphm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    input  wire  i_req_stall,
    input  t_req i_req,
    input  wire  i_rsp_valid,
    input  wire  i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // Shadow copy of the map
    logic [63:0] shadow_keys [TABLE_DEPTH];
    logic [63:0] shadow_vals [TABLE_DEPTH];
    bit          slot_full   [TABLE_DEPTH];
    int          home_cnt    [TABLE_DEPTH];
    int          stored_count;
    t_rsp        rsp_queue [$];

    function automatic int home_of(logic [63:0] key);
        logic [63:0] prod;
        prod = key * {32'd0, HASH_MULT};
        return int'(prod[IDX_W-1:0]);
    endfunction

    // Walk the probe sequence for one request and update the shadow map
    function automatic t_rsp map_access(t_req req);
        t_rsp rsp;
        int   home;
        int   need;
        int   seen;
        int   pos;
        int   steps;
        bit   hit;
        home  = home_of(req.key);
        need  = home_cnt[home];
        seen  = 0;
        pos   = home;
        steps = 0;
        hit   = 0;
        while (seen < need && steps < TABLE_DEPTH && !hit) begin
            if (slot_full[pos] && shadow_keys[pos] == req.key) begin
                hit = 1;
            end else begin
                if (slot_full[pos] && home_of(shadow_keys[pos]) == home) seen++;
                pos   = (pos + 1) % TABLE_DEPTH;
                steps++;
            end
        end
        rsp.result_value = '0;
        if (req.req_type == REQ_LOOKUP) begin
            rsp.status       = hit ? ST_FOUND : ST_NOT_FOUND;
            rsp.result_value = hit ? shadow_vals[pos] : MISS_VALUE;
        end else if (hit) begin
            rsp.status = ST_PRESENT;
        end else if (stored_count >= TABLE_DEPTH / 2) begin
            rsp.status = ST_FULL;
        end else begin
            // Advance to the next free slot
            while (slot_full[pos]) pos = (pos + 1) % TABLE_DEPTH;
            shadow_keys[pos] = req.key;
            shadow_vals[pos] = req.value;
            slot_full[pos]   = 1;
            home_cnt[home]++;
            stored_count++;
            rsp.status = ST_INSERTED;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_full[i] = 0;
                home_cnt[i]  = 0;
            end
            stored_count = 0;
            o_fail_count = 0;
            rsp_queue.delete();
            o_pending    = 0;
        end else begin
            // Predict on each accepted request transaction
            if (i_req_valid && !i_req_stall) rsp_queue.push_back(map_access(i_req));
            // Compare each accepted response transaction
            if (i_rsp_valid && !i_rsp_stall) begin
                if (rsp_queue.size() == 0) begin
                    $error("unexpected response transaction");
                    o_fail_count++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (i_rsp.result_value !== want.result_value) begin
                        $error("result_value: expected %h actual %h",
                               want.result_value, i_rsp.result_value);
                        o_fail_count++;
                    end
                end
            end
            o_pending = rsp_queue.size();
        end
    end

endmodule

[tb/tb_linear_probe_hash_map_top.sv]
// Testbench top for the linear-probing hash map: clock, reset, request
// stimulus and verdict. Depends on lphm_pkg, the block and lphm_checker.
`timescale 1ns / 1ps
module tb_linear_probe_hash_map_top;
    import lphm_pkg::*;

    localparam int TABLE_DEPTH = 1024;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    bit   calm;
    logic [63:0] used_keys [$];

    linear_probe_hash_map_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
    );

    lphm_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .i_req_stall(o_req_stall), .i_req(i_req),
        .i_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .i_rsp(o_rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run length
    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    // Random receiver stall, quiet during calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) i_rsp_stall <= 1'b0;
        else          i_rsp_stall <= !calm && ($urandom_range(99) < 11);
    end

    // Drive one request transaction and hold it until accepted
    task automatic send_req(logic rtype, logic [63:0] key, logic [63:0] val);
        while (!calm && $urandom_range(99) < 11) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid    <= 1'b1;
        i_req.req_type <= rtype;
        i_req.key      <= key;
        i_req.value    <= val;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        if (rtype == REQ_INSERT) used_keys.push_back(key);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keys with a chosen home pick up collisions: search upward from a random key
    function automatic logic [63:0] key_for_home(int home);
        logic [63:0] k;
        k = rand64();
        while (((k * 64'd3474692833) & (TABLE_DEPTH - 1)) != home) k = k + 1;
        return k;
    endfunction

    initial begin
        logic [63:0] k;
        int          n;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        i_rsp_stall = 1'b0;
        calm        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, duplicates, misses, miss-value payload
        send_req(REQ_LOOKUP, 64'd0, '1);
        send_req(REQ_INSERT, 64'd0, 64'd0);
        send_req(REQ_INSERT, '1, '1);
        send_req(REQ_INSERT, 64'd5, MISS_VALUE);
        send_req(REQ_INSERT, 64'd0, 64'h1234);
        send_req(REQ_LOOKUP, 64'd0, 64'd0);
        send_req(REQ_LOOKUP, '1, 64'd0);
        send_req(REQ_LOOKUP, 64'd5, 64'd0);
        send_req(REQ_LOOKUP, 64'h8000_0000_0000_0000, '1);
        for (int i = 0; i < 6; i++) send_req(REQ_INSERT, key_for_home(7), rand64());
        send_req(REQ_INSERT, key_for_home(8), rand64());
        send_req(REQ_INSERT, key_for_home(TABLE_DEPTH - 1), rand64());
        send_req(REQ_INSERT, key_for_home(TABLE_DEPTH - 1), rand64());
        for (int i = 0; i < 4; i++) send_req(REQ_LOOKUP, used_keys[5 + i], 64'd0);
        send_req(REQ_LOOKUP, key_for_home(7), 64'd0);

        // Pause until every expected response has come
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random mix; a calm stretch in the middle
        for (int i = 0; i < 100; i++) begin
            calm = (i >= 30 && i < 80);
            n = $urandom_range(99);
            if (n < 40)      k = key_for_home($urandom_range(TABLE_DEPTH - 1) & 'h3f);
            else if (n < 55) k = rand64();
            else             k = used_keys[$urandom_range(used_keys.size() - 1)];
            send_req($urandom_range(1), k, rand64());
        end
        calm = 1'b0;

        // Fill to half capacity, then exercise the full case
        while (used_keys.size() < TABLE_DEPTH / 2 + 60)
            send_req(REQ_INSERT, rand64(), rand64());
        for (int i = 0; i < 20; i++)
            send_req($urandom_range(1), used_keys[$urandom_range(used_keys.size() - 1)],
                     rand64());
        send_req(REQ_INSERT, rand64(), rand64());
        i_req_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("TB_OK");
        else                 $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/lphm_pkg.sv
src/linear_probe_hash_map_top.sv
tb/lphm_checker.sv
tb/tb_linear_probe_hash_map_top.sv
